### hdl/cluster_current_water_fill_unit_macros.svh
// Assertion macros used by the checker file of the current water fill unit.
`ifndef CLUSTER_CURRENT_WATER_FILL_UNIT_MACROS_SVH
`define CLUSTER_CURRENT_WATER_FILL_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cwf_pkg.sv
// Package with types, widths and constants of the current water fill unit.
package cwf_pkg;

    localparam int NODE_COUNT_DEF = 8;
    localparam int SCALE          = 10;

    localparam int CUR_W      = 12;
    localparam int SIG_W      = 16;
    localparam int POOL_W     = 14;
    localparam int NODE_NUM_W = 3;
    localparam int LIMIT_W    = 10;
    localparam int MIN_W      = 7;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 2;

    localparam logic signed [SIG_W-1:0] SOLAR_MAINS_THRESHOLD = 16'sd10;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd16;
    localparam logic [MIN_W-1:0]   MIN_RESET   = 7'd6;

    localparam logic OP_STATUS    = 1'b0;
    localparam logic OP_REBALANCE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CIRCUIT_LIMIT = 2'd0,
        REG_MIN_NODE      = 2'd1,
        REG_SOLAR_MODE    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             active;
        logic [CUR_W-1:0] limit;
    } node_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_EV,
        ST_CHECK,
        ST_D1_START,
        ST_D1_WAIT,
        ST_P1_RD,
        ST_P1_EV,
        ST_P2_RD,
        ST_P2_EV,
        ST_D2_START,
        ST_D2_WAIT,
        ST_OUT_RD,
        ST_OUT_EM,
        ST_REFUSE
    } state_t;

endpackage

### hdl/cwf_ram.sv
// Generic single write port RAM with one registered read port.
module cwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/cwf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module cwf_div #(
    parameter int DW = 14,
    parameter int VW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DW - 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [VW:0]      shifted;
    logic [VW+1:0]    diff;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            if (diff[VW+1])
            begin
                rem_next = shifted[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            if (cnt_reg == LAST_CNT)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/cluster_current_water_fill_unit.sv
// Top level of the cluster current water fill unit.
//
// A command beat is taken at a rising edge with start high and busy low.
// A status write (operation 0) stores one node's charging flag and maximum
// current in the node table in that same cycle; busy stays low and no result
// follows. A rebalance (operation 1) raises busy until its last result.
// Results appear one beat per strobe on result_valid; last marks the final
// beat. A refused rebalance gives a single beat with not_enough_power set.
// Otherwise NODE_COUNT beats follow in node order. A rebalance sweeps the
// node table, checks whether the power suffices, then divides the remaining
// current once before each pass of the capping scan and once per node that
// takes a fair share, scans the nodes in both passes, and last reads out
// the current table for the result beats.
// Configuration registers are written through cfg_write at any idle cycle.
// Reset clears both tables to zero through valid bits, restores register
// defaults and leaves the block idle at once. The receiver cannot stall;
// every result beat is taken in the cycle it is shown.
module cluster_current_water_fill_unit #(
    parameter int NODE_COUNT = cwf_pkg::NODE_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  operation,
    input  logic [cwf_pkg::NODE_NUM_W-1:0]        node_index,
    input  logic                                  node_active,
    input  logic [cwf_pkg::CUR_W-1:0]             node_max_current,
    input  logic signed [cwf_pkg::SIG_W-1:0]      requested_current,
    input  logic signed [cwf_pkg::SIG_W-1:0]      phase_current,
    input  logic signed [cwf_pkg::SIG_W-1:0]      total_mains_current,
    input  logic signed [cwf_pkg::SIG_W-1:0]      available_current,
    input  logic                                  cfg_write,
    input  logic [cwf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cwf_pkg::CFG_W-1:0]             cfg_data,
    output logic                                  result_valid,
    output logic [cwf_pkg::NODE_NUM_W-1:0]        node_number,
    output logic [cwf_pkg::CUR_W-1:0]             charge_current,
    output logic                                  not_enough_power,
    output logic                                  last
);

    import cwf_pkg::*;

    localparam int IW     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CW     = $clog2(NODE_COUNT + 1);
    localparam int SW     = CUR_W + CW;
    localparam int NEED_W = CW + MIN_W + 4;
    localparam int CMPN_W = (NEED_W > SIG_W - 1) ? NEED_W : SIG_W - 1;
    localparam int CMPP_W = (SW > SIG_W - 1) ? SW : SIG_W - 1;
    localparam int ENT_W  = CUR_W + 1;
    localparam logic [IW-1:0] LAST_NODE = IW'(NODE_COUNT - 1);

    logic [LIMIT_W-1:0] limit_reg;
    logic [MIN_W-1:0]   min_reg;
    logic               solar_reg;

    state_t                  state_reg, state_next;
    logic [IW-1:0]           node_reg, node_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [SW-1:0]           sum_reg, sum_next;
    logic [POOL_W-1:0]       pool_reg, pool_next;
    logic [NODE_COUNT-1:0]   done_reg, done_next;
    logic signed [SIG_W-1:0] total_reg;
    logic                    solar_hit_reg;
    logic [NODE_COUNT-1:0]   a_valid_reg;
    logic [NODE_COUNT-1:0]   b_valid_reg;

    logic signed [SIG_W-1:0] cap_total;
    logic                    accept;
    logic                    a_we;
    logic [ENT_W-1:0]        a_rdata;
    node_entry_t             a_wentry;
    node_entry_t             a_ent;
    logic                    b_we;
    logic [CUR_W-1:0]        b_wdata;
    logic [CUR_W-1:0]        b_rdata;
    logic                    div_start;
    logic                    div_done;
    logic [POOL_W-1:0]       div_quot;
    logic [NEED_W-1:0]       need;
    logic                    refuse;
    logic                    eligible;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign a_we   = accept && (operation == OP_STATUS) && (int'(node_index) < NODE_COUNT);

    assign a_wentry.active = node_active;
    assign a_wentry.limit  = node_max_current;

    assign cap_total = signed'(SIG_W'(limit_reg) * SIG_W'(SCALE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            min_reg   <= MIN_RESET;
            solar_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CIRCUIT_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_MIN_NODE:      min_reg   <= cfg_data[MIN_W-1:0];
                REG_SOLAR_MODE:    solar_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    cwf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NODE_COUNT),
        .AW    (IW)
    ) u_node_table (
        .clk   (clk),
        .we    (a_we),
        .waddr (IW'(node_index)),
        .wdata (a_wentry),
        .raddr (node_reg),
        .rdata (a_rdata)
    );

    cwf_ram #(
        .WIDTH (CUR_W),
        .DEPTH (NODE_COUNT),
        .AW    (IW)
    ) u_current_table (
        .clk   (clk),
        .we    (b_we),
        .waddr (node_reg),
        .wdata (b_wdata),
        .raddr (node_reg),
        .rdata (b_rdata)
    );

    cwf_div #(
        .DW (POOL_W),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pool_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign a_ent    = a_valid_reg[node_reg] ? node_entry_t'(a_rdata) : '0;
    assign eligible = a_ent.active && !done_reg[node_reg];
    assign need     = NEED_W'(count_reg) * NEED_W'(min_reg) * NEED_W'(SCALE);
    assign refuse   = solar_hit_reg || total_reg[SIG_W-1] ||
                      (CMPN_W'(total_reg[SIG_W-2:0]) < CMPN_W'(need));

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        pool_next  = pool_reg;
        done_next  = done_reg;
        b_we       = 1'b0;
        b_wdata    = a_ent.limit;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (operation == OP_REBALANCE))
                begin
                    node_next  = '0;
                    count_next = '0;
                    sum_next   = '0;
                    done_next  = '0;
                    state_next = ST_SUM_RD;
                end
            end
            ST_SUM_RD:
            begin
                state_next = ST_SUM_EV;
            end
            ST_SUM_EV:
            begin
                if (a_ent.active)
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + SW'(a_ent.limit);
                end
                if (node_reg == LAST_NODE)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    node_next  = node_reg + 1'b1;
                    state_next = ST_SUM_RD;
                end
            end
            ST_CHECK:
            begin
                node_next = '0;
                if (refuse)
                begin
                    state_next = ST_REFUSE;
                end
                else
                begin
                    pool_next = (CMPP_W'(total_reg[SIG_W-2:0]) < CMPP_W'(sum_reg)) ?
                                POOL_W'(total_reg[SIG_W-2:0]) : POOL_W'(sum_reg);
                    state_next = (count_reg == '0) ? ST_OUT_RD : ST_D1_START;
                end
            end
            ST_D1_START:
            begin
                div_start  = 1'b1;
                state_next = ST_D1_WAIT;
            end
            ST_D1_WAIT:
            begin
                if (div_done)
                begin
                    node_next  = '0;
                    state_next = ST_P1_RD;
                end
            end
            ST_P1_RD:
            begin
                state_next = ST_P1_EV;
            end
            ST_P1_EV:
            begin
                if (eligible && (div_quot >= POOL_W'(a_ent.limit)))
                begin
                    b_we                = 1'b1;
                    b_wdata             = a_ent.limit;
                    done_next[node_reg] = 1'b1;
                    count_next          = count_reg - 1'b1;
                    pool_next           = pool_reg - POOL_W'(a_ent.limit);
                    node_next           = '0;
                    state_next          = (count_reg == CW'(1)) ? ST_OUT_RD : ST_D1_START;
                end
                else if (node_reg == LAST_NODE)
                begin
                    node_next  = '0;
                    state_next = ST_P2_RD;
                end
                else
                begin
                    node_next  = node_reg + 1'b1;
                    state_next = ST_P1_RD;
                end
            end
            ST_P2_RD:
            begin
                state_next = ST_P2_EV;
            end
            ST_P2_EV:
            begin
                if (eligible)
                begin
                    state_next = ST_D2_START;
                end
                else if (node_reg == LAST_NODE)
                begin
                    node_next  = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    node_next  = node_reg + 1'b1;
                    state_next = ST_P2_RD;
                end
            end
            ST_D2_START:
            begin
                div_start  = 1'b1;
                state_next = ST_D2_WAIT;
            end
            ST_D2_WAIT:
            begin
                if (div_done)
                begin
                    b_we                = 1'b1;
                    b_wdata             = div_quot[CUR_W-1:0];
                    done_next[node_reg] = 1'b1;
                    count_next          = count_reg - 1'b1;
                    pool_next           = pool_reg - div_quot;
                    if ((count_reg == CW'(1)) || (node_reg == LAST_NODE))
                    begin
                        node_next  = '0;
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        node_next  = node_reg + 1'b1;
                        state_next = ST_P2_RD;
                    end
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_EM;
            end
            ST_OUT_EM:
            begin
                if (node_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    node_next  = node_reg + 1'b1;
                    state_next = ST_OUT_RD;
                end
            end
            ST_REFUSE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            node_reg    <= '0;
            count_reg   <= '0;
            done_reg    <= '0;
            a_valid_reg <= '0;
            b_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (a_we)
            begin
                a_valid_reg[IW'(node_index)] <= 1'b1;
            end
            if (b_we)
            begin
                b_valid_reg[node_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        pool_reg <= pool_next;
        if (accept)
        begin
            total_reg     <= (requested_current < cap_total) ? requested_current : cap_total;
            solar_hit_reg <= solar_reg && (total_mains_current > SOLAR_MAINS_THRESHOLD) &&
                             (phase_current > available_current);
        end
    end

    assign result_valid     = (state_reg == ST_OUT_EM) || (state_reg == ST_REFUSE);
    assign not_enough_power = (state_reg == ST_REFUSE);
    assign node_number      = (state_reg == ST_OUT_EM) ? NODE_NUM_W'(node_reg) : '0;
    assign charge_current   = ((state_reg == ST_OUT_EM) && b_valid_reg[node_reg]) ?
                              b_rdata : '0;
    assign last             = (state_reg == ST_REFUSE) ||
                              ((state_reg == ST_OUT_EM) && (node_reg == LAST_NODE));

endmodule

### hdl/cwf_checker.sv
// Port-level checker of the current water fill unit and its bind statement.
`include "cluster_current_water_fill_unit_macros.svh"

module cwf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           operation,
    input logic                           result_valid,
    input logic [cwf_pkg::NODE_NUM_W-1:0] node_number,
    input logic [cwf_pkg::CUR_W-1:0]      charge_current,
    input logic                           not_enough_power,
    input logic                           last
);

    import cwf_pkg::*;

    `CWF_ASSERT_SAME(a_result_in_busy, result_valid, busy, "result beat while idle")
    `CWF_ASSERT_NEXT(a_rebal_busy, start && !busy && (operation == OP_REBALANCE), busy, "rebalance did not raise busy")
    `CWF_ASSERT_NEXT(a_status_idle, start && !busy && (operation == OP_STATUS), !busy, "status write left the unit busy")
    `CWF_ASSERT_SAME(a_refuse_beat, result_valid && not_enough_power, last && (charge_current == '0) && (node_number == '0), "malformed refusal beat")
    `CWF_ASSERT_NEXT(a_last_frees, result_valid && last, !busy, "unit busy after last beat")

endmodule

bind cluster_current_water_fill_unit cwf_checker u_cwf_checker (.*);

### tb/cluster_current_water_fill_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cluster current water fill unit.
module cluster_current_water_fill_unit_test;
    import cwf_pkg::*;

    localparam int NODES         = NODE_COUNT_DEF;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 500;

    typedef struct packed {
        logic                  op;
        logic [NODE_NUM_W-1:0] idx;
        logic                  act;
        logic [CUR_W-1:0]      maxc;
        logic [SIG_W-1:0]      req;
        logic [SIG_W-1:0]      phase;
        logic [SIG_W-1:0]      mains;
        logic [SIG_W-1:0]      avail;
    } fill_cmd_t;

    typedef struct packed {
        logic [NODE_NUM_W-1:0] node;
        logic [CUR_W-1:0]      amps;
        logic                  refused;
        logic                  tail;
    } alloc_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic operation;
    logic [NODE_NUM_W-1:0] node_index;
    logic node_active;
    logic [CUR_W-1:0] node_max_current;
    logic signed [SIG_W-1:0] requested_current;
    logic signed [SIG_W-1:0] phase_current;
    logic signed [SIG_W-1:0] total_mains_current;
    logic signed [SIG_W-1:0] available_current;
    logic cfg_write;
    cfg_reg_t cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic result_valid;
    logic [NODE_NUM_W-1:0] node_number;
    logic [CUR_W-1:0] charge_current;
    logic not_enough_power;
    logic last;

    logic [NODES-1:0] node_on;
    logic [CUR_W-1:0] node_cap [NODES];
    logic [CUR_W-1:0] node_share [NODES];
    logic [LIMIT_W-1:0] lim_amps;
    logic [MIN_W-1:0] floor_amps;
    logic solar_on;

    alloc_beat_t expected_allocs [$];
    alloc_beat_t want_beat;
    int mismatches = 0;
    int stall_cycles = 0;
    int idle_pct = 0;

    cluster_current_water_fill_unit uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .operation           (operation),
        .node_index          (node_index),
        .node_active         (node_active),
        .node_max_current    (node_max_current),
        .requested_current   (requested_current),
        .phase_current       (phase_current),
        .total_mains_current (total_mains_current),
        .available_current   (available_current),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .result_valid        (result_valid),
        .node_number         (node_number),
        .charge_current      (charge_current),
        .not_enough_power    (not_enough_power),
        .last                (last)
    );

    always #5 clk = ~clk;

    function automatic void predict_allocation(input fill_cmd_t c);
        int total;
        int heads;
        int ceiling;
        int pool;
        int share;
        int n;
        logic [NODES-1:0] capped;
        alloc_beat_t beat;
        total = int'(lim_amps) * SCALE;
        if (int'($signed(c.req)) < total)
            total = int'($signed(c.req));
        heads = 0;
        ceiling = 0;
        capped = '0;
        for (n = 0; n < NODES; n++)
        begin
            if (node_on[n])
            begin
                heads++;
                ceiling += int'(node_cap[n]);
            end
        end
        if (total < heads * int'(floor_amps) * SCALE
            || (solar_on && $signed(c.mains) > SOLAR_MAINS_THRESHOLD
                && $signed(c.phase) > $signed(c.avail)))
        begin
            beat.node = '0;
            beat.amps = '0;
            beat.refused = 1'b1;
            beat.tail = 1'b1;
            expected_allocs.push_back(beat);
            return;
        end
        pool = (total < ceiling) ? total : ceiling;
        if (heads > 0)
        begin
            // Nodes whose maximum fits under the fair share are capped first,
            // and the scan starts over from node 0 after each cap.
            n = 0;
            while (n < NODES && heads > 0)
            begin
                share = pool / heads;
                if (node_on[n] && !capped[n] && share >= int'(node_cap[n]))
                begin
                    node_share[n] = node_cap[n];
                    capped[n] = 1'b1;
                    heads--;
                    pool -= int'(node_cap[n]);
                    n = 0;
                end
                else
                begin
                    n++;
                end
            end
            for (n = 0; n < NODES && heads > 0; n++)
            begin
                if (node_on[n] && !capped[n])
                begin
                    share = pool / heads;
                    node_share[n] = share[CUR_W-1:0];
                    capped[n] = 1'b1;
                    heads--;
                    pool -= share;
                end
            end
        end
        for (n = 0; n < NODES; n++)
        begin
            beat.node = n[NODE_NUM_W-1:0];
            beat.amps = node_share[n];
            beat.refused = 1'b0;
            beat.tail = (n == NODES - 1);
            expected_allocs.push_back(beat);
        end
    endfunction

    function automatic fill_cmd_t status_cmd(input int idx, input logic act, input int cap);
        fill_cmd_t c;
        c.op = OP_STATUS;
        c.idx = idx[NODE_NUM_W-1:0];
        c.act = act;
        c.maxc = cap[CUR_W-1:0];
        c.req = SIG_W'($urandom_range(0, 65535));
        c.phase = SIG_W'($urandom_range(0, 65535));
        c.mains = SIG_W'($urandom_range(0, 65535));
        c.avail = SIG_W'($urandom_range(0, 65535));
        return c;
    endfunction

    function automatic fill_cmd_t rebalance_cmd(input int req, input int phase,
                                                input int mains, input int avail);
        fill_cmd_t c;
        c.op = OP_REBALANCE;
        c.idx = NODE_NUM_W'($urandom_range(0, NODES - 1));
        c.act = 1'($urandom_range(0, 1));
        c.maxc = CUR_W'($urandom_range(0, 4095));
        c.req = req[SIG_W-1:0];
        c.phase = phase[SIG_W-1:0];
        c.mains = mains[SIG_W-1:0];
        c.avail = avail[SIG_W-1:0];
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_cmd(input fill_cmd_t c);
        while ($urandom_range(0, 99) < idle_pct)
            @(negedge clk);
        operation = c.op;
        node_index = c.idx;
        node_active = c.act;
        node_max_current = c.maxc;
        requested_current = c.req;
        phase_current = c.phase;
        total_mains_current = c.mains;
        available_current = c.avail;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (c.op == OP_STATUS)
        begin
            node_on[c.idx] = c.act;
            node_cap[c.idx] = c.maxc;
        end
        else
        begin
            predict_allocation(c);
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic settle_idle();
        while (busy || expected_allocs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input int value);
        settle_idle();
        cfg_write = 1'b1;
        cfg_index = sel;
        cfg_data = value[CFG_W-1:0];
        @(negedge clk);
        cfg_write = 1'b0;
        case (sel)
            REG_CIRCUIT_LIMIT: lim_amps = value[LIMIT_W-1:0];
            REG_MIN_NODE:      floor_amps = value[MIN_W-1:0];
            REG_SOLAR_MODE:    solar_on = value[0];
            default:           ;
        endcase
    endtask

    task automatic test_empty_cluster();
        send_cmd(rebalance_cmd(100, 0, 0, 0));
        send_cmd(rebalance_cmd(-32768, 0, 0, 0));
        send_cmd(rebalance_cmd(0, 32767, 32767, -32768));
    endtask

    task automatic test_minimum_refusal();
        send_cmd(status_cmd(0, 1'b1, 0));
        send_cmd(status_cmd(3, 1'b1, 100));
        send_cmd(status_cmd(5, 1'b1, 2000));
        send_cmd(status_cmd(7, 1'b1, 4095));
        send_cmd(rebalance_cmd(200, 0, 0, 0));
    endtask

    task automatic test_water_fill();
        write_reg(REG_CIRCUIT_LIMIT, 600);
        write_reg(REG_MIN_NODE, 1);
        send_cmd(rebalance_cmd(32767, 0, 0, 0));
        send_cmd(rebalance_cmd(39, 0, 0, 0));
        send_cmd(rebalance_cmd(40, 0, 0, 0));
        send_cmd(status_cmd(5, 1'b0, 2000));
        send_cmd(status_cmd(2, 1'b1, 4095));
        send_cmd(rebalance_cmd(1000, 0, 0, 0));
    endtask

    task automatic test_solar_refusal();
        write_reg(REG_SOLAR_MODE, 1);
        send_cmd(rebalance_cmd(32767, 5, 11, 4));
        send_cmd(rebalance_cmd(32767, 5, 10, 4));
        send_cmd(rebalance_cmd(32767, 4, 11, 4));
        send_cmd(rebalance_cmd(32767, 32767, 32767, -32768));
        send_cmd(rebalance_cmd(32767, 32767, -32768, -32768));
    endtask

    task automatic test_register_extremes();
        write_reg(REG_CIRCUIT_LIMIT, 0);
        write_reg(REG_MIN_NODE, 0);
        write_reg(REG_SOLAR_MODE, 0);
        send_cmd(rebalance_cmd(500, 0, 0, 0));
        write_reg(REG_CIRCUIT_LIMIT, 600);
        write_reg(REG_MIN_NODE, 80);
        send_cmd(rebalance_cmd(3199, 0, 0, 0));
        send_cmd(rebalance_cmd(3200, 0, 0, 0));
    endtask

    task automatic test_random_traffic(input int pct, input int items);
        int sent;
        int next_retune;
        int heads;
        int req;
        int cap;
        int n;
        logic [95:0] noise;
        sent = 0;
        next_retune = 0;
        while (sent < items)
        begin
            if (sent >= next_retune)
            begin
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_CIRCUIT_LIMIT, 0);
                    1:       write_reg(REG_CIRCUIT_LIMIT, 600);
                    default: write_reg(REG_CIRCUIT_LIMIT, $urandom_range(1, 600));
                endcase
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_MIN_NODE, 0);
                    1:       write_reg(REG_MIN_NODE, 80);
                    default: write_reg(REG_MIN_NODE, $urandom_range(0, 12));
                endcase
                write_reg(REG_SOLAR_MODE, $urandom_range(0, 1));
                next_retune = sent + 40;
            end
            idle_pct = pct;
            if ($urandom_range(0, 9) == 0)
            begin
                noise = {$urandom, $urandom, $urandom};
                send_cmd(noise[$bits(fill_cmd_t)-1:0]);
                sent++;
            end
            else
            begin
                repeat ($urandom_range(0, 4))
                begin
                    case ($urandom_range(0, 9))
                        0:       cap = 0;
                        1:       cap = $urandom_range(0, 4095);
                        default: cap = $urandom_range(1, 700);
                    endcase
                    send_cmd(status_cmd($urandom_range(0, NODES - 1),
                                        $urandom_range(0, 99) < 65, cap));
                    sent++;
                end
                heads = 0;
                for (n = 0; n < NODES; n++)
                    heads += int'(node_on[n]);
                case ($urandom_range(0, 9))
                    0:       req = $urandom_range(0, 65535);
                    1, 2:    req = heads * int'(floor_amps) * SCALE + $urandom_range(0, 4) - 2;
                    default: req = $urandom_range(0, 6100);
                endcase
                if ($urandom_range(0, 3) == 0)
                    send_cmd(rebalance_cmd(req, $urandom_range(0, 65535),
                                           $urandom_range(0, 65535), $urandom_range(0, 65535)));
                else
                    send_cmd(rebalance_cmd(req, $urandom_range(0, 600),
                                           $urandom_range(0, 30), $urandom_range(0, 600)));
                sent++;
            end
        end
        idle_pct = 0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_allocs.size() == 0)
            begin
                mismatches++;
                $display("%0t: beat with none expected: node %0d current %0d refused %0b last %0b",
                         $time, node_number, charge_current, not_enough_power, last);
            end
            else
            begin
                want_beat = expected_allocs.pop_front();
                if (node_number !== want_beat.node)
                begin
                    mismatches++;
                    $display("%0t: node_number expected %0d actual %0d",
                             $time, want_beat.node, node_number);
                end
                if (charge_current !== want_beat.amps)
                begin
                    mismatches++;
                    $display("%0t: charge_current expected %0d actual %0d",
                             $time, want_beat.amps, charge_current);
                end
                if (not_enough_power !== want_beat.refused)
                begin
                    mismatches++;
                    $display("%0t: not_enough_power expected %0b actual %0b",
                             $time, want_beat.refused, not_enough_power);
                end
                if (last !== want_beat.tail)
                begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b", $time, want_beat.tail, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
        begin
            stall_cycles = 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stall_cycles++;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_STATUS;
        node_index = '0;
        node_active = 1'b0;
        node_max_current = '0;
        requested_current = '0;
        phase_current = '0;
        total_mains_current = '0;
        available_current = '0;
        cfg_write = 1'b0;
        cfg_index = REG_CIRCUIT_LIMIT;
        cfg_data = '0;
        node_on = '0;
        for (int n = 0; n < NODES; n++)
        begin
            node_cap[n] = '0;
            node_share[n] = '0;
        end
        lim_amps = LIMIT_RESET;
        floor_amps = MIN_RESET;
        solar_on = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        idle_pct = 23;
        test_empty_cluster();
        test_minimum_refusal();
        test_water_fill();
        test_solar_refusal();
        test_register_extremes();
        test_random_traffic(23, 125);
        test_random_traffic(69, 125);
        test_random_traffic(0, 120);

        while (expected_allocs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
